>>> rtl/sps_pkg.sv
// shared types and constants for the stepper phase sequencer
// no dependencies; imported by every module of the block

package sps_pkg;

  localparam int MODE_W       = 3;
  localparam int TEMP_W       = 10;
  localparam int HUM_W        = 7;
  localparam int PHASE_W      = 2;
  localparam int COIL_W       = 4;
  localparam int SWEEP_LEN_W  = 12;
  localparam int WINDOW_W     = 8;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_IDX_W    = 1;

  localparam logic [SWEEP_LEN_W-1:0] SWEEP_LEN_RESET = 12'd2080;
  localparam logic [WINDOW_W-1:0]    WINDOW_RESET    = 8'd50;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE        = 3'd0,
    MODE_FOLLOW_TEMP = 3'd1,
    MODE_FOLLOW_HUM  = 3'd2,
    MODE_CW          = 3'd3,
    MODE_CCW         = 3'd4,
    MODE_SWEEP       = 3'd5
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWEEP_LENGTH  = 1'd0,
    CFG_FOLLOW_WINDOW = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [MODE_W-1:0]        movement_mode;
    logic signed [TEMP_W-1:0] temperature_f;
    logic [HUM_W-1:0]         humidity;
  } item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [COIL_W-1:0]  coil_drive;
    logic               sweep_forward;
  } result_t;

  typedef struct packed {
    logic [SWEEP_LEN_W-1:0] sweep_length;
    logic [WINDOW_W-1:0]    follow_window;
  } cfg_t;

  function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
    logic [COIL_W-1:0] pat;
    unique case (phase)
      2'd0: pat = 4'hC;
      2'd1: pat = 4'h6;
      2'd2: pat = 4'h3;
      2'd3: pat = 4'h9;
      default: pat = 4'hC;
    endcase
    return pat;
  endfunction

endpackage

>>> rtl/stepper_phase_sequencer.sv
// top level of the stepper phase sequencer: input register, step unit, result register
// depends on sps_pkg, sps_cfg_regs and sps_step_unit
//
// usage:
//   input channel: in_valid_i / in_stall_o with movement_mode_i, temperature_f_i and
//   humidity_i; one word is one step period. output channel: out_valid_o / out_stall_i
//   with phase_o, coil_drive_o and sweep_forward_o; one result word per input word.
//   config channel: cfg_valid_i / cfg_ready_o with cfg_index_i (0 sweep length,
//   1 follow window) and cfg_data_i; always ready, write only while the block is idle.
//   a word accepted is held in the input register; its result is computed from it and
//   registered in the result register, from which the output shows it.
//   throughput: one word per cycle while the output is not stalled; the state update is a
//   single pass of logic from the input register to the result register.
//   stall: while the output is stalled the result holds, the input register keeps
//   its word and in_stall_o rises once that register is full.
//   reset: both registers empty, phase 0, sweep count 0 counting up, stored readings
//   zero, follow timer saturated, sweep length 2080, follow window 50.

module stepper_phase_sequencer #(
  parameter int SWEEP_COUNT_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sps_pkg::MODE_W-1:0]        movement_mode_i,
  input  logic signed [sps_pkg::TEMP_W-1:0] temperature_f_i,
  input  logic [sps_pkg::HUM_W-1:0]         humidity_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sps_pkg::PHASE_W-1:0]       phase_o,
  output logic [sps_pkg::COIL_W-1:0]        coil_drive_o,
  output logic                              sweep_forward_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sps_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import sps_pkg::*;

  item_t   item_q;
  logic    in_valid_q, in_valid_d;
  result_t res_q, res_next;
  logic    out_valid_q, out_valid_d;
  cfg_t    cfg;
  logic    out_ready, advance, accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.movement_mode <= movement_mode_i;
      item_q.temperature_f <= temperature_f_i;
      item_q.humidity      <= humidity_i;
    end
    if (advance) begin
      res_q <= res_next;
    end
  end

  sps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sps_step_unit #(
    .SWEEP_COUNT_BITS (SWEEP_COUNT_BITS)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_next)
  );

  assign out_valid_o     = out_valid_q;
  assign phase_o         = res_q.phase;
  assign coil_drive_o    = res_q.coil_drive;
  assign sweep_forward_o = res_q.sweep_forward;

  a_advance_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("consumed word produced no result");

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with nothing pending");

  a_coil_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (coil_drive_o == coil_pattern(phase_o)))
    else $error("coil pattern does not match phase");

endmodule

>>> rtl/sps_cfg_regs.sv
// configuration registers: sweep length and follow window
// depends on sps_pkg

module sps_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sps_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output sps_pkg::cfg_t                     cfg_o
);
  import sps_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SWEEP_LENGTH:  cfg_d.sweep_length  = cfg_data_i[SWEEP_LEN_W-1:0];
        CFG_FOLLOW_WINDOW: cfg_d.follow_window = cfg_data_i[WINDOW_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sweep_length  <= SWEEP_LEN_RESET;
      cfg_q.follow_window <= WINDOW_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/sps_step_unit.sv
// phase, sweep and follow-timer state with the per-period update logic
// depends on sps_pkg

module sps_step_unit #(
  parameter int SWEEP_COUNT_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  sps_pkg::item_t    item_i,
  input  sps_pkg::cfg_t     cfg_i,
  output sps_pkg::result_t  res_o
);
  import sps_pkg::*;

  localparam int CmpW = (SWEEP_COUNT_BITS > SWEEP_LEN_W) ? SWEEP_COUNT_BITS : SWEEP_LEN_W;
  localparam logic [SWEEP_COUNT_BITS-1:0] CountMax = '1;

  logic [PHASE_W-1:0]          phase_q, phase_d;
  logic [SWEEP_COUNT_BITS-1:0] count_q, count_d;
  logic                        up_q, up_d;
  logic [TEMP_W-1:0]           prev_temp_q, prev_temp_d;
  logic [HUM_W-1:0]            prev_hum_q, prev_hum_d;
  logic [WINDOW_W-1:0]         since_q, since_d;

  logic                        changed;
  logic [WINDOW_W-1:0]         since_inc;
  logic [SWEEP_COUNT_BITS-1:0] count_inc, count_dec;
  logic [CmpW-1:0]             count_ext, len_ext;

  always_comb begin
    changed = (mode_e'(item_i.movement_mode) == MODE_FOLLOW_TEMP)
              ? (item_i.temperature_f != prev_temp_q)
              : (item_i.humidity != prev_hum_q);
    since_inc = (since_q != '1) ? since_q + 1'b1 : since_q;
    count_inc = (count_q != CountMax) ? count_q + 1'b1 : count_q;
    count_dec = (count_q != '0) ? count_q - 1'b1 : count_q;
    count_ext = CmpW'(count_inc);
    len_ext   = CmpW'(cfg_i.sweep_length);
  end

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    up_d        = up_q;
    prev_temp_d = prev_temp_q;
    prev_hum_d  = prev_hum_q;
    since_d     = since_q;
    unique case (mode_e'(item_i.movement_mode))
      MODE_FOLLOW_TEMP, MODE_FOLLOW_HUM: begin
        prev_temp_d = item_i.temperature_f;
        prev_hum_d  = item_i.humidity;
        if (changed) begin
          since_d = '0;
        end else begin
          since_d = since_inc;
          if (since_inc < cfg_i.follow_window) begin
            phase_d = phase_q - 1'b1;
          end
        end
      end
      MODE_CW:  phase_d = phase_q - 1'b1;
      MODE_CCW: phase_d = phase_q + 1'b1;
      MODE_SWEEP: begin
        if (up_q) begin
          phase_d = phase_q - 1'b1;
          count_d = count_inc;
          if (count_ext >= len_ext || count_inc == CountMax) begin
            up_d = 1'b0;
          end
        end else begin
          phase_d = phase_q + 1'b1;
          count_d = count_dec;
          if (count_dec == '0) begin
            up_d = 1'b1;
          end
        end
      end
      default: phase_d = phase_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      count_q     <= '0;
      up_q        <= 1'b1;
      prev_temp_q <= '0;
      prev_hum_q  <= '0;
      since_q     <= '1;
    end else if (en_i) begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      up_q        <= up_d;
      prev_temp_q <= prev_temp_d;
      prev_hum_q  <= prev_hum_d;
      since_q     <= since_d;
    end
  end

  assign res_o.phase         = phase_d;
  assign res_o.coil_drive    = coil_pattern(phase_d);
  assign res_o.sweep_forward = up_d;

  // state only moves when an item is consumed
  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> ($stable(phase_q) && $stable(count_q) && $stable(up_q) && $stable(since_q)))
    else $error("step state changed without an item");

  // a down sweep never sits at a zero count
  a_zero_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> up_q)
    else $error("sweep count zero while sweeping down");

  // phase moves at most one step per item
  a_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> (phase_q == $past(phase_q) || phase_q == $past(phase_q) + 2'd1
              || phase_q == $past(phase_q) - 2'd1))
    else $error("phase jumped by more than one step");

endmodule

>>> bench/stepper_phase_sequencer_test.sv
// self-checking bench for stepper_phase_sequencer: directed and random step words, random gaps
// and output stalls, register writes between phases; results checked against a phase predictor
// depends on sps_pkg and the rtl of the block
`timescale 1ns / 1ps

module stepper_phase_sequencer_test;
  import sps_pkg::*;

  localparam int          SWEEP_BITS    = 12;
  localparam logic [15:0] COIL_BY_PHASE = 16'h936C;
  localparam int          CYCLE_LIMIT   = 600000;

  class step_predictor;
    logic [PHASE_W-1:0]     phase_idx;
    logic [SWEEP_BITS-1:0]  sweep_cnt;
    logic                   sweep_fwd;
    logic [TEMP_W-1:0]      last_temp;
    logic [HUM_W-1:0]       last_hum;
    logic [WINDOW_W-1:0]    quiet_periods;
    logic [SWEEP_LEN_W-1:0] sweep_len;
    logic [WINDOW_W-1:0]    window;
    result_t                expected_steps[$];
    int                     mismatches;

    function new();
      phase_idx     = '0;
      sweep_cnt     = '0;
      sweep_fwd     = 1'b1;
      last_temp     = '0;
      last_hum      = '0;
      quiet_periods = '1;
      sweep_len     = SWEEP_LEN_RESET;
      window        = WINDOW_RESET;
      mismatches    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_SWEEP_LENGTH) sweep_len = data[SWEEP_LEN_W-1:0];
      else window = data[WINDOW_W-1:0];
    endfunction

    function void take_word(item_t w);
      result_t r;
      logic    changed;
      case (w.movement_mode)
        MODE_FOLLOW_TEMP, MODE_FOLLOW_HUM: begin
          if (w.movement_mode == MODE_FOLLOW_TEMP) changed = (w.temperature_f != last_temp);
          else changed = (w.humidity != last_hum);
          if (changed) begin
            quiet_periods = '0;
          end else begin
            if (quiet_periods != '1) quiet_periods++;
            if (quiet_periods < window) phase_idx--;
          end
          last_temp = w.temperature_f;
          last_hum  = w.humidity;
        end
        MODE_CW: phase_idx--;
        MODE_CCW: phase_idx++;
        MODE_SWEEP: begin
          if (sweep_fwd) begin
            phase_idx--;
            if (sweep_cnt != '1) sweep_cnt++;
            if (sweep_cnt >= sweep_len || sweep_cnt == '1) sweep_fwd = 1'b0;
          end else begin
            phase_idx++;
            if (sweep_cnt != '0) sweep_cnt--;
            if (sweep_cnt == '0) sweep_fwd = 1'b1;
          end
        end
        default: ;
      endcase
      r.phase         = phase_idx;
      r.coil_drive    = COIL_BY_PHASE[phase_idx*4 +: 4];
      r.sweep_forward = sweep_fwd;
      expected_steps.push_back(r);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_steps.size() == 0) begin
        $error("result word with no step pending: phase %0d coil %h", got.phase, got.coil_drive);
        mismatches++;
        return;
      end
      want = expected_steps.pop_front();
      if (got.phase !== want.phase) begin
        $error("phase: expected %0d, got %0d", want.phase, got.phase);
        mismatches++;
      end
      if (got.coil_drive !== want.coil_drive) begin
        $error("coil_drive: expected %h, got %h", want.coil_drive, got.coil_drive);
        mismatches++;
      end
      if (got.sweep_forward !== want.sweep_forward) begin
        $error("sweep_forward: expected %0d, got %0d", want.sweep_forward, got.sweep_forward);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [MODE_W-1:0]        movement_mode_i;
  logic signed [TEMP_W-1:0] temperature_f_i;
  logic [HUM_W-1:0]         humidity_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [PHASE_W-1:0]       phase_o;
  logic [COIL_W-1:0]        coil_drive_o;
  logic                     sweep_forward_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_DATA_W-1:0]    cfg_data_i;

  step_predictor sb = new();
  item_t         live;
  bit            tx_calm;
  bit            rx_calm;
  int            cycle_count;

  stepper_phase_sequencer #(
    .SWEEP_COUNT_BITS(SWEEP_BITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .movement_mode_i (movement_mode_i),
    .temperature_f_i (temperature_f_i),
    .humidity_i      (humidity_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .phase_o         (phase_o),
    .coil_drive_o    (coil_drive_o),
    .sweep_forward_o (sweep_forward_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_word(item_t w);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    movement_mode_i <= w.movement_mode;
    temperature_f_i <= w.temperature_f;
    humidity_i      <= w.humidity;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_word(w);
  endtask

  task automatic send_fields(mode_e m, int t, int h);
    item_t w;
    w.movement_mode = m;
    w.temperature_f = t[TEMP_W-1:0];
    w.humidity      = h[HUM_W-1:0];
    send_word(w);
  endtask

  // sensor readings and mode drift slowly so follow windows and sweeps play out
  task automatic send_random(int n);
    int t;
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) live.movement_mode = MODE_W'($urandom_range(0, 7));
      if ($urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 9) == 0) t = $urandom_range(0, 1023);
        else t = $urandom_range(0, 297) - 40;
        live.temperature_f = t[TEMP_W-1:0];
      end
      if ($urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 9) == 0) live.humidity = HUM_W'($urandom_range(0, 127));
        else live.humidity = HUM_W'($urandom_range(0, 100));
      end
      send_word(live);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_steps.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_config(logic [SWEEP_LEN_W-1:0] len, logic [CFG_DATA_W-1:0] win);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_SWEEP_LENGTH;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(CFG_SWEEP_LENGTH, len);
    cfg_index_i <= CFG_FOLLOW_WINDOW;
    cfg_data_i  <= win;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(CFG_FOLLOW_WINDOW, win);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    movement_mode_i <= '0;
    temperature_f_i <= '0;
    humidity_i      <= '0;
    out_stall_i     <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_SWEEP_LENGTH;
    cfg_data_i      <= '0;
    live            = '0;
    tx_calm         = 1'b0;
    rx_calm         = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: follow timer starts saturated, readings start at zero
    send_fields(MODE_IDLE, 0, 0);
    send_fields(MODE_FOLLOW_TEMP, 0, 0);
    send_fields(MODE_FOLLOW_TEMP, 257, 100);
    send_fields(MODE_FOLLOW_TEMP, 257, 0);
    send_fields(MODE_FOLLOW_HUM, 257, 0);
    send_fields(MODE_FOLLOW_HUM, -40, 100);
    send_fields(MODE_FOLLOW_HUM, 0, 100);
    send_fields(MODE_FOLLOW_TEMP, 0, 127);
    send_fields(MODE_CW, -512, 127);
    send_fields(MODE_CW, 511, 0);
    send_fields(MODE_CCW, -1, 1);
    send_fields(MODE_CCW, 0, 0);
    send_fields(MODE_CCW, 0, 0);
    send_word(item_t'({3'd6, 10'h2AA, 7'h55}));
    send_word(item_t'({3'd7, 10'h155, 7'h2A}));
    repeat (4) send_fields(MODE_SWEEP, -40, 100);
    send_fields(MODE_FOLLOW_TEMP, 0, 127);
    send_fields(MODE_FOLLOW_HUM, 0, 127);
    send_fields(MODE_IDLE, 257, 0);
    send_random(200);
    drain();

    set_config(12'd1, 12'd255);
    send_random(120);
    drain();

    // long sweep: count turns at its length and runs back to zero
    set_config(12'd37, 12'hF01);
    live.movement_mode = MODE_SWEEP;
    repeat (100) send_word(live);
    send_random(40);
    drain();

    repeat (4) begin
      set_config(SWEEP_LEN_W'($urandom_range(1, 24)),
                 {4'($urandom_range(0, 15)), 8'($urandom_range(1, 40))});
      send_random(80);
      drain();
    end

    set_config(SWEEP_LEN_RESET, 12'd1);
    send_random(40);
    drain();

    if (sb.mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    result_t got;
    int      hold;
    @(posedge rst_ni);
    forever begin
      hold = rx_calm ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.phase         = phase_o;
      got.coil_drive    = coil_drive_o;
      got.sweep_forward = sweep_forward_o;
      sb.check_word(got);
    end
  end

endmodule

>>> stepper_phase_sequencer.f
rtl/sps_pkg.sv
rtl/sps_cfg_regs.sv
rtl/sps_step_unit.sv
rtl/stepper_phase_sequencer.sv
bench/stepper_phase_sequencer_test.sv
